// ----- hdl/ibed_pkg.sv -----
// ----------------------------------------------------------------------------
// ibed_pkg
// Types, codes and confidence maps shared by the impact and brake detector.
// ----------------------------------------------------------------------------
package ibed_pkg;

  localparam int SAMPLE_RATE_HZ = 50;
  localparam int JERK_W         = $clog2(65535 * SAMPLE_RATE_HZ + 1);
  localparam int CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CRASH_MAG_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRASH_JERK_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_JERK_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_MAG_CEIL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRASH_COOLDOWN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_COOLDOWN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_HOLD       = 3'd6;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_BRAKE  = 2'd1;
  localparam logic [1:0] MODE_CRASH  = 2'd2;

  localparam logic [1:0] EV_NONE         = 2'd0;
  localparam logic [1:0] EV_BRAKE_START  = 2'd1;
  localparam logic [1:0] EV_BRAKE_EXTEND = 2'd2;
  localparam logic [1:0] EV_CRASH        = 2'd3;

  localparam logic [15:0] PREV_MAG_RESET = 16'd4096;

  // map bounds in Q4.12, jerk in g/s and magnitude in g
  localparam logic [31:0] BRAKE_LO  = 32'(14 * 4096);
  localparam logic [31:0] BRAKE_R   = 32'(16 * 4096);
  localparam logic [31:0] CJERK_LO  = 32'(40 * 4096);
  localparam logic [31:0] CJERK_R   = 32'(50 * 4096);
  localparam logic [15:0] CMAG_LO   = 16'(3 * 4096);
  localparam logic [15:0] CMAG_R    = 16'(2 * 4096);

  typedef struct packed {
    logic        command;
    logic [15:0] accel_magnitude;
    logic [31:0] timestamp_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic [7:0] confidence;
    logic [1:0] mode;
  } out_item_t;

  typedef struct packed {
    logic [15:0] crash_magnitude_limit;
    logic [15:0] crash_jerk_limit;
    logic [15:0] brake_jerk_limit;
    logic [15:0] brake_magnitude_ceiling;
    logic [15:0] crash_cooldown_ms;
    logic [15:0] brake_cooldown_ms;
    logic [15:0] brake_hold_ms;
  } cfg_t;

  function automatic logic [8:0] div5(input logic [10:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'(52429);
    return p[26:18];
  endfunction

  function automatic logic [8:0] div125(input logic [14:0] x);
    logic [30:0] p;
    p = 31'(x) * 31'(33555);
    return p[30:22];
  endfunction

  function automatic logic [7:0] sat8(input logic [8:0] v);
    return v[8] ? 8'hFF : v[7:0];
  endfunction

  // floor((16384 + c) / 320)
  function automatic logic [7:0] conf_brake(input logic [JERK_W-1:0] jerk);
    logic [31:0] j;
    logic [31:0] c;
    logic [16:0] n;
    j = 32'(jerk);
    c = (j > BRAKE_LO) ? (j - BRAKE_LO) : 32'd0;
    if (c > BRAKE_R) c = BRAKE_R;
    n = 17'(c) + 17'd16384;
    return sat8(div5(n[16:6]));
  endfunction

  // floor((51200 + c) / 1000)
  function automatic logic [7:0] conf_crash_jerk(input logic [JERK_W-1:0] jerk);
    logic [31:0] j;
    logic [31:0] c;
    logic [17:0] n;
    j = 32'(jerk);
    c = (j > CJERK_LO) ? (j - CJERK_LO) : 32'd0;
    if (c > CJERK_R) c = CJERK_R;
    n = 18'(c) + 18'd51200;
    return sat8(div125(n[17:3]));
  endfunction

  // floor((2048 + c) / 40)
  function automatic logic [7:0] conf_crash_mag(input logic [15:0] mag);
    logic [15:0] c;
    logic [13:0] n;
    c = (mag > CMAG_LO) ? (mag - CMAG_LO) : 16'd0;
    if (c > CMAG_R) c = CMAG_R;
    n = 14'(c) + 14'd2048;
    return sat8(div5(n[13:3]));
  endfunction

endpackage

// ----- hdl/ibed_cfg.sv -----
// ----------------------------------------------------------------------------
// ibed_cfg
// Threshold, cooldown and hold registers with their write port.
// ----------------------------------------------------------------------------
module ibed_cfg
  import ibed_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_CRASH_MAG_LIMIT:  cfg_nxt.crash_magnitude_limit   = cfg_data;
        REG_CRASH_JERK_LIMIT: cfg_nxt.crash_jerk_limit        = cfg_data;
        REG_BRAKE_JERK_LIMIT: cfg_nxt.brake_jerk_limit        = cfg_data;
        REG_BRAKE_MAG_CEIL:   cfg_nxt.brake_magnitude_ceiling = cfg_data;
        REG_CRASH_COOLDOWN:   cfg_nxt.crash_cooldown_ms       = cfg_data;
        REG_BRAKE_COOLDOWN:   cfg_nxt.brake_cooldown_ms       = cfg_data;
        REG_BRAKE_HOLD:       cfg_nxt.brake_hold_ms           = cfg_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crash_magnitude_limit   <= 16'd12288;
      cfg_r.crash_jerk_limit        <= 16'd3277;
      cfg_r.brake_jerk_limit        <= 16'd1147;
      cfg_r.brake_magnitude_ceiling <= 16'd9011;
      cfg_r.crash_cooldown_ms       <= 16'd2500;
      cfg_r.brake_cooldown_ms       <= 16'd200;
      cfg_r.brake_hold_ms           <= 16'd800;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hdl/ibed_detect.sv -----
// ----------------------------------------------------------------------------
// ibed_detect
// Detector state and the single-pass crash, brake and expiry decision.
// ----------------------------------------------------------------------------
module ibed_detect
  import ibed_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_item_t  item,
  input  logic      adv,
  output out_item_t result
);

  logic [15:0] prev_mag_r,   prev_mag_nxt;
  logic [31:0] last_crash_r, last_crash_nxt;
  logic [31:0] last_brake_r, last_brake_nxt;
  logic [31:0] brake_end_r,  brake_end_nxt;
  logic [1:0]  mode_r,       mode_nxt;

  logic [1:0]        mode_e;
  logic [31:0]       past;
  logic [15:0]       d;
  logic [JERK_W-1:0] jerk;
  logic [31:0]       since_c;
  logic [31:0]       since_b;
  logic              crash_hit;
  logic              brake_hit;
  logic [7:0]        c1;
  logic [7:0]        c2;

  always_comb begin
    past    = item.timestamp_ms - brake_end_r;
    mode_e  = mode_r;
    if (mode_r == MODE_BRAKE && past != 32'd0 && !past[31]) mode_e = MODE_NORMAL;

    d = (item.accel_magnitude > prev_mag_r) ? (item.accel_magnitude - prev_mag_r)
                                           : (prev_mag_r - item.accel_magnitude);
    jerk    = JERK_W'(32'(d) * 32'(SAMPLE_RATE_HZ));
    since_c = item.timestamp_ms - last_crash_r;
    since_b = item.timestamp_ms - last_brake_r;

    crash_hit = (mode_e != MODE_CRASH) && (since_c >= 32'(cfg.crash_cooldown_ms)) &&
                ((item.accel_magnitude > cfg.crash_magnitude_limit) ||
                 (d > cfg.crash_jerk_limit));
    brake_hit = (since_b >= 32'(cfg.brake_cooldown_ms)) && (d > cfg.brake_jerk_limit) &&
                (item.accel_magnitude < cfg.brake_magnitude_ceiling);

    c1 = conf_crash_jerk(jerk);
    c2 = conf_crash_mag(item.accel_magnitude);

    prev_mag_nxt      = prev_mag_r;
    last_crash_nxt    = last_crash_r;
    last_brake_nxt    = last_brake_r;
    brake_end_nxt     = brake_end_r;
    mode_nxt          = mode_r;
    result.event_code = EV_NONE;
    result.confidence = 8'd0;

    if (item.command) begin
      mode_nxt = MODE_NORMAL;
    end else begin
      prev_mag_nxt = item.accel_magnitude;
      mode_nxt     = mode_e;
      if (crash_hit) begin
        last_crash_nxt    = item.timestamp_ms;
        mode_nxt          = MODE_CRASH;
        result.event_code = EV_CRASH;
        result.confidence = (c1 > c2) ? c1 : c2;
      end else if (brake_hit) begin
        last_brake_nxt = item.timestamp_ms;
        brake_end_nxt  = item.timestamp_ms + 32'(cfg.brake_hold_ms);
        if (mode_e == MODE_BRAKE) begin
          result.event_code = EV_BRAKE_EXTEND;
        end else begin
          mode_nxt          = MODE_BRAKE;
          result.event_code = EV_BRAKE_START;
          result.confidence = conf_brake(jerk);
        end
      end
    end
    result.mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mag_r   <= PREV_MAG_RESET;
      last_crash_r <= 32'd0;
      last_brake_r <= 32'd0;
      brake_end_r  <= 32'd0;
      mode_r       <= MODE_NORMAL;
    end else if (adv) begin
      prev_mag_r   <= prev_mag_nxt;
      last_crash_r <= last_crash_nxt;
      last_brake_r <= last_brake_nxt;
      brake_end_r  <= brake_end_nxt;
      mode_r       <= mode_nxt;
    end
  end

  a_dismiss_normal: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.command |=> mode_r == MODE_NORMAL)
    else $error("dismiss did not return to normal");

  a_crash_mode: assert property (@(posedge clk) disable iff (!rst_n)
    result.event_code == EV_CRASH |-> result.mode == MODE_CRASH)
    else $error("crash event without crash mode");

  a_conf_start_only: assert property (@(posedge clk) disable iff (!rst_n)
    result.confidence != 8'd0 |->
      (result.event_code == EV_CRASH || result.event_code == EV_BRAKE_START))
    else $error("confidence on a non-start event");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(mode_r) && $stable(prev_mag_r) && $stable(brake_end_r))
    else $error("state moved without an item");

endmodule

// ----- hdl/impact_brake_event_detector.sv -----
// ----------------------------------------------------------------------------
// impact_brake_event_detector
// Crash and hard-brake event detection on a stream of magnitude samples.
//
//   port group   direction  flow control   word
//   in_*         input      valid / stall  in_item_t
//   out_*        output     valid / stall  out_item_t
//   cfg_*        input      valid / ready  index + 16-bit data
//
// One word per cycle sustained while out_* is not stalled; a word taken sits in
// the input register, then moves to the output register that drives out_*, and
// leaves from there when out_stall is low.
// The state update and decision for a word happen as it moves between the
// two registers, so back-to-back words see each other's state.
// Reset is synchronous; the detector state and thresholds take their defaults.
// A stall on out_* holds the result; in_stall rises only when both registers
// are full and out_* is stalled.
// ----------------------------------------------------------------------------
module impact_brake_event_detector
  import ibed_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t      cfg;
  in_item_t  in_data_r;
  logic      in_valid_r;
  out_item_t out_data_r;
  logic      out_valid_r;
  out_item_t result;
  logic      adv;
  logic      in_take;

  assign adv       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !adv;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ibed_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ibed_detect u_detect (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .item   (in_data_r),
    .adv    (adv),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= result;
    end
  end

endmodule
